@@ rtl/assert_macros.svh @@
// Assertion macros used by the plbc_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLBC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define PLBC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

@@ rtl/plbc_pkg.sv @@
// ----------------------------------------------------------------------------
// plbc_pkg
// Types and fixed constants of the power LED breathing controller.
// ----------------------------------------------------------------------------
package plbc_pkg;

   // Request codes
   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_RESUME   = 3'd1;
   localparam logic [2:0] REQ_SUSPEND  = 3'd2;
   localparam logic [2:0] REQ_SHUTDOWN = 3'd3;
   localparam logic [2:0] REQ_ALERT_ON = 3'd4;
   localparam logic [2:0] REQ_ALERT_OFF = 3'd5;
   localparam logic [2:0] REQ_CRITICAL = 3'd6;
   localparam logic [2:0] REQ_MANUAL   = 3'd7;

   // System mode codes
   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_ON      = 2'd1;
   localparam logic [1:0] MODE_SUSPEND = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam int          ADDR_W            = 5;
   localparam logic [2:0]  REG_AUTO_ENABLE    = 3'd0;
   localparam logic [2:0]  REG_PULSE_INTERVAL = 3'd1;
   localparam logic [2:0]  REG_PULSE_STEP     = 3'd2;
   localparam logic [2:0]  REG_ALERT_INTERVAL = 3'd3;
   localparam logic [2:0]  REG_OFF_DELAY      = 3'd4;

   // Register reset values
   localparam logic        RST_AUTO_ENABLE    = 1'b1;
   localparam logic [15:0] RST_PULSE_INTERVAL = 16'd40;
   localparam logic [6:0]  RST_PULSE_STEP     = 7'd2;
   localparam logic [15:0] RST_ALERT_INTERVAL = 16'd1000;
   localparam logic [15:0] RST_OFF_DELAY      = 16'd2000;

   typedef logic [7:0]        level_type;
   typedef logic signed [8:0] delta_type;

   typedef struct packed {
      level_type level;
      delta_type delta;
   } pulse_type;

endpackage

@@ rtl/plbc_if.sv @@
// ----------------------------------------------------------------------------
// plbc_req_if / plbc_rsp_if
// Valid/ready channels carrying LED requests and duty responses.
// ----------------------------------------------------------------------------
interface plbc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] manual_red;
   logic [7:0] manual_white;

   modport source (output valid, req_type, manual_red, manual_white, input ready);
   modport sink   (input valid, req_type, manual_red, manual_white, output ready);
endinterface

interface plbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] red_duty;
   logic [6:0] white_duty;
   logic       set_error;

   modport source (output valid, red_duty, white_duty, set_error, input ready);
   modport sink   (input valid, red_duty, white_duty, set_error, output ready);
endinterface

@@ rtl/power_led_breathing_controller_unit.sv @@
// Flow: an accepted request waits in the input register until the response slot
// is free. Throughput: one request per cycle unless the response stalls; the state
// update is one short pass between the input register and the response register.
// Reset (synchronous, active high) clears all LED state and the pipeline and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// power_led_breathing_controller_unit
// Red/white power-LED duty control from system events, ticks and manual sets.
// ----------------------------------------------------------------------------
module power_led_breathing_controller_unit #(
   parameter int COUNT_WIDTH = 16,
   parameter int FULL_DUTY   = 100
) (
   input  logic                           clock,
   input  logic                           reset,
   plbc_req_if.sink                       req,
   plbc_rsp_if.source                     rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [plbc_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam plbc_pkg::level_type FULL_LVL = 8'(FULL_DUTY);
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   // Configuration registers
   logic        auto_enable_ff;
   logic [15:0] pulse_interval_ff;
   logic [6:0]  pulse_step_ff;
   logic [15:0] alert_interval_ff;
   logic [15:0] off_delay_ff;
   logic        cfg_write;
   logic [2:0]  cfg_index;

   // Input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [2:0] req_type_ff;
   logic [7:0] manual_red_ff, manual_white_ff;

   // Response stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] red_duty_ff, white_duty_ff;
   logic       set_error_ff, set_error_in;

   // LED state
   logic [1:0]             mode_ff, mode_in;
   logic                   pulse_running_ff, pulse_running_in;
   logic [COUNT_WIDTH-1:0] pulse_cnt_ff, pulse_cnt_in;
   logic [COUNT_WIDTH-1:0] pulse_period_ff, pulse_period_in;
   plbc_pkg::delta_type    pulse_delta_ff, pulse_delta_in;
   logic                   pulse_red_ff, pulse_red_in;
   plbc_pkg::level_type    pulse_level_ff, pulse_level_in;
   logic                   susp_pend_ff, susp_pend_in;
   logic                   shut_pend_ff, shut_pend_in;
   logic [COUNT_WIDTH-1:0] delay_cnt_ff, delay_cnt_in;
   plbc_pkg::level_type    red_level_ff, red_level_in;
   plbc_pkg::level_type    white_level_ff, white_level_in;

   logic stall;
   logic advance;
   logic fire;
   plbc_pkg::pulse_type adv;

   // One breathing step: flip the sign at the ends, then clamp
   function automatic plbc_pkg::pulse_type pulse_step_calc(
      input plbc_pkg::level_type lvl,
      input plbc_pkg::delta_type dlt
   );
      logic signed [9:0]   sum;
      plbc_pkg::delta_type d;
      plbc_pkg::pulse_type r;
      d   = dlt;
      sum = $signed({2'b00, lvl}) + 10'(d);
      if (sum > $signed({2'b00, FULL_LVL}) || sum < 0) begin
         d   = -dlt;
         sum = $signed({2'b00, lvl}) + 10'(d);
      end
      if (sum < 0) begin
         r.level = '0;
      end else if (sum > $signed({2'b00, FULL_LVL})) begin
         r.level = FULL_LVL;
      end else begin
         r.level = sum[7:0];
      end
      r.delta = d;
      return r;
   endfunction

   // Configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = paddr[plbc_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_enable_ff    <= plbc_pkg::RST_AUTO_ENABLE;
         pulse_interval_ff <= plbc_pkg::RST_PULSE_INTERVAL;
         pulse_step_ff     <= plbc_pkg::RST_PULSE_STEP;
         alert_interval_ff <= plbc_pkg::RST_ALERT_INTERVAL;
         off_delay_ff      <= plbc_pkg::RST_OFF_DELAY;
      end else if (cfg_write) begin
         case (cfg_index)
            plbc_pkg::REG_AUTO_ENABLE:    auto_enable_ff    <= pwdata[0];
            plbc_pkg::REG_PULSE_INTERVAL: pulse_interval_ff <= pwdata[15:0];
            plbc_pkg::REG_PULSE_STEP:     pulse_step_ff     <= pwdata[6:0];
            plbc_pkg::REG_ALERT_INTERVAL: alert_interval_ff <= pwdata[15:0];
            plbc_pkg::REG_OFF_DELAY:      off_delay_ff      <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Register read back
   always_comb begin
      case (cfg_index)
         plbc_pkg::REG_AUTO_ENABLE:    prdata = {31'd0, auto_enable_ff};
         plbc_pkg::REG_PULSE_INTERVAL: prdata = {16'd0, pulse_interval_ff};
         plbc_pkg::REG_PULSE_STEP:     prdata = {25'd0, pulse_step_ff};
         plbc_pkg::REG_ALERT_INTERVAL: prdata = {16'd0, alert_interval_ff};
         plbc_pkg::REG_OFF_DELAY:      prdata = {16'd0, off_delay_ff};
         default:                      prdata = '0;
      endcase
   end

   // Handshake: the input stage advances whenever the response slot is free
   assign stall       = rsp_valid_ff && !rsp.ready;
   assign advance     = s1_valid_ff && !stall;
   assign req.ready   = !s1_valid_ff || !stall;
   assign s1_valid_in = (req.valid && req.ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Next LED state for the request in the input stage
   always_comb begin
      mode_in          = mode_ff;
      pulse_running_in = pulse_running_ff;
      pulse_cnt_in     = pulse_cnt_ff;
      pulse_period_in  = pulse_period_ff;
      pulse_delta_in   = pulse_delta_ff;
      pulse_red_in     = pulse_red_ff;
      pulse_level_in   = pulse_level_ff;
      susp_pend_in     = susp_pend_ff;
      shut_pend_in     = shut_pend_ff;
      delay_cnt_in     = delay_cnt_ff;
      red_level_in     = red_level_ff;
      white_level_in   = white_level_ff;
      set_error_in     = 1'b0;
      fire             = 1'b0;
      adv              = '0;

      if (advance) begin
         case (req_type_ff)
            plbc_pkg::REQ_TICK: begin
               // Serve the running pulse first
               if (pulse_running_ff) begin
                  if (pulse_cnt_ff <= CNT_ONE) begin
                     if (auto_enable_ff) begin
                        adv            = pulse_step_calc(pulse_level_ff, pulse_delta_ff);
                        red_level_in   = pulse_red_ff ? pulse_level_ff : '0;
                        white_level_in = pulse_red_ff ? '0 : pulse_level_ff;
                        pulse_level_in = adv.level;
                        pulse_delta_in = adv.delta;
                     end
                     pulse_cnt_in = pulse_period_ff;
                  end else begin
                     pulse_cnt_in = pulse_cnt_ff - CNT_ONE;
                  end
               end
               // Then count down the pending delay
               if (susp_pend_ff || shut_pend_ff) begin
                  fire = (delay_cnt_ff <= CNT_ONE);
                  if (delay_cnt_ff != '0) begin
                     delay_cnt_in = delay_cnt_ff - CNT_ONE;
                  end
               end
               if (fire && susp_pend_ff) begin
                  // Start the white breathing ramp from zero
                  susp_pend_in     = 1'b0;
                  pulse_period_in  = COUNT_WIDTH'(pulse_interval_ff);
                  pulse_red_in     = 1'b0;
                  pulse_running_in = 1'b1;
                  pulse_level_in   = '0;
                  pulse_delta_in   = $signed({2'b00, pulse_step_ff});
                  if (auto_enable_ff) begin
                     adv            = pulse_step_calc('0, $signed({2'b00, pulse_step_ff}));
                     red_level_in   = '0;
                     white_level_in = '0;
                     pulse_level_in = adv.level;
                     pulse_delta_in = adv.delta;
                  end
                  pulse_cnt_in = COUNT_WIDTH'(pulse_interval_ff);
               end else if (fire && shut_pend_ff) begin
                  shut_pend_in = 1'b0;
                  if (auto_enable_ff) begin
                     red_level_in   = '0;
                     white_level_in = '0;
                  end
               end
            end
            plbc_pkg::REQ_RESUME, plbc_pkg::REQ_SUSPEND, plbc_pkg::REQ_SHUTDOWN,
            plbc_pkg::REQ_ALERT_OFF: begin
               // Alert-off replays the last system state event
               if (req_type_ff == plbc_pkg::REQ_RESUME) begin
                  mode_in = plbc_pkg::MODE_ON;
               end else if (req_type_ff == plbc_pkg::REQ_SUSPEND) begin
                  mode_in = plbc_pkg::MODE_SUSPEND;
               end else if (req_type_ff == plbc_pkg::REQ_SHUTDOWN) begin
                  mode_in = plbc_pkg::MODE_OFF;
               end
               if (mode_in == plbc_pkg::MODE_ON) begin
                  pulse_running_in = 1'b0;
                  susp_pend_in     = 1'b0;
                  shut_pend_in     = 1'b0;
                  if (auto_enable_ff) begin
                     red_level_in   = '0;
                     white_level_in = FULL_LVL;
                  end
               end else if (mode_in == plbc_pkg::MODE_SUSPEND) begin
                  shut_pend_in = 1'b0;
                  susp_pend_in = 1'b1;
                  delay_cnt_in = COUNT_WIDTH'(off_delay_ff);
               end else begin
                  pulse_running_in = 1'b0;
                  susp_pend_in     = 1'b0;
                  shut_pend_in     = 1'b1;
                  delay_cnt_in     = COUNT_WIDTH'(off_delay_ff);
               end
            end
            plbc_pkg::REQ_ALERT_ON: begin
               // Start the red full-swing blink
               pulse_period_in  = COUNT_WIDTH'(alert_interval_ff);
               pulse_red_in     = 1'b1;
               pulse_running_in = 1'b1;
               pulse_level_in   = '0;
               pulse_delta_in   = $signed({1'b0, FULL_LVL});
               if (auto_enable_ff) begin
                  adv            = pulse_step_calc('0, $signed({1'b0, FULL_LVL}));
                  red_level_in   = '0;
                  white_level_in = '0;
                  pulse_level_in = adv.level;
                  pulse_delta_in = adv.delta;
               end
               pulse_cnt_in = COUNT_WIDTH'(alert_interval_ff);
            end
            plbc_pkg::REQ_CRITICAL: begin
               pulse_running_in = 1'b0;
               if (auto_enable_ff) begin
                  red_level_in   = FULL_LVL;
                  white_level_in = '0;
               end
            end
            default: begin
               // Manual set: red wins over white, refuse values above full duty
               if (manual_red_ff != '0) begin
                  if (manual_red_ff > FULL_LVL) begin
                     set_error_in = 1'b1;
                  end else begin
                     red_level_in   = manual_red_ff;
                     white_level_in = '0;
                  end
               end else if (manual_white_ff != '0) begin
                  if (manual_white_ff > FULL_LVL) begin
                     set_error_in = 1'b1;
                  end else begin
                     red_level_in   = '0;
                     white_level_in = manual_white_ff;
                  end
               end else begin
                  red_level_in   = '0;
                  white_level_in = '0;
               end
            end
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         mode_ff          <= plbc_pkg::MODE_OFF;
         pulse_running_ff <= 1'b0;
         pulse_cnt_ff     <= '0;
         pulse_period_ff  <= '0;
         pulse_delta_ff   <= '0;
         pulse_red_ff     <= 1'b0;
         pulse_level_ff   <= '0;
         susp_pend_ff     <= 1'b0;
         shut_pend_ff     <= 1'b0;
         delay_cnt_ff     <= '0;
         red_level_ff     <= '0;
         white_level_ff   <= '0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         mode_ff          <= mode_in;
         pulse_running_ff <= pulse_running_in;
         pulse_cnt_ff     <= pulse_cnt_in;
         pulse_period_ff  <= pulse_period_in;
         pulse_delta_ff   <= pulse_delta_in;
         pulse_red_ff     <= pulse_red_in;
         pulse_level_ff   <= pulse_level_in;
         susp_pend_ff     <= susp_pend_in;
         shut_pend_ff     <= shut_pend_in;
         delay_cnt_ff     <= delay_cnt_in;
         red_level_ff     <= red_level_in;
         white_level_ff   <= white_level_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_type_ff     <= req.req_type;
         manual_red_ff   <= req.manual_red;
         manual_white_ff <= req.manual_white;
      end
      if (advance) begin
         red_duty_ff   <= red_level_in[6:0];
         white_duty_ff <= white_level_in[6:0];
         set_error_ff  <= set_error_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.red_duty   = red_duty_ff;
   assign rsp.white_duty = white_duty_ff;
   assign rsp.set_error  = set_error_ff;

endmodule

@@ rtl/plbc_checker.sv @@
// ----------------------------------------------------------------------------
// plbc_checker
// Port-level checks of the power LED breathing controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plbc_checker #(
   parameter int FULL_DUTY = 100
) (
   input logic        clock,
   input logic        reset,
   plbc_req_if.sink   req,
   plbc_rsp_if.source rsp
);

   // Drop any response in flight on reset
   `PLBC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp.valid)

   // A free response slot always lets a request in
   `PLBC_ASSERT(a_ready_when_free, clock, reset, !rsp.valid |-> req.ready)

   // Only one color is lit at a time
   `PLBC_ASSERT(a_one_color, clock, reset,
      rsp.valid |-> (rsp.red_duty == 7'd0 || rsp.white_duty == 7'd0))

   // Hold a stalled response
   `PLBC_ASSERT(a_rsp_hold, clock, reset,
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.red_duty) &&
      $stable(rsp.white_duty) && $stable(rsp.set_error)))

   // Duties never exceed full scale
   `PLBC_ASSERT(a_duty_range, clock, reset,
      rsp.valid |-> (32'(rsp.red_duty) <= 32'(FULL_DUTY) &&
      32'(rsp.white_duty) <= 32'(FULL_DUTY)))

endmodule

bind power_led_breathing_controller_unit plbc_checker #(
   .FULL_DUTY(FULL_DUTY)
) u_plbc_checker (
   .clock(clock),
   .reset(reset),
   .req  (req),
   .rsp  (rsp)
);
